FILE: rtl/acme_pkg.sv
package acme_pkg;

    // Defaults for the top-level parameters.
    localparam int ENTRIES_DEF     = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int HANDLE_BITS_DEF = 16;

    // Fixed field widths of the stream payloads.
    localparam int FIELD_BITS  = 16;
    localparam int SLOT_BITS   = 4;
    localparam int STAMP_BITS  = 32;
    localparam int IN_DATA_BITS  = 2 * FIELD_BITS;
    localparam int OUT_PAD_BITS  = 4;
    localparam int OUT_DATA_BITS = 2 * FIELD_BITS + SLOT_BITS + OUT_PAD_BITS;
    localparam int OUT_USER_BITS = 2;

    // Operation codes carried in the input tuser.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Write enables from the sequencer to the entry store.
    typedef struct packed {
        logic stamp_en;  // write the use stamp of the addressed entry
        logic entry_en;  // write key and handle and mark the entry valid
    } acme_wr_t;

endpackage

FILE: rtl/acme_store.sv
module acme_store #(
    parameter int ENTRIES     = acme_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = acme_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = acme_pkg::HANDLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [$clog2(ENTRIES)-1:0]      rd_addr,
    output logic                            rd_valid,
    output logic [KEY_BITS-1:0]             rd_key,
    output logic [HANDLE_BITS-1:0]          rd_handle,
    output logic [acme_pkg::STAMP_BITS-1:0] rd_stamp,
    input  acme_pkg::acme_wr_t              wr,
    input  logic [$clog2(ENTRIES)-1:0]      wr_addr,
    input  logic [KEY_BITS-1:0]             wr_key,
    input  logic [HANDLE_BITS-1:0]          wr_handle,
    input  logic [acme_pkg::STAMP_BITS-1:0] wr_stamp
);

    logic [KEY_BITS-1:0]             key_mem    [ENTRIES];
    logic [HANDLE_BITS-1:0]          handle_mem [ENTRIES];
    logic [acme_pkg::STAMP_BITS-1:0] stamp_mem  [ENTRIES];

    logic [ENTRIES-1:0]              valid_reg;
    logic [ENTRIES-1:0]              valid_next;
    logic                            rd_valid_reg;
    logic [KEY_BITS-1:0]             rd_key_reg;
    logic [HANDLE_BITS-1:0]          rd_handle_reg;
    logic [acme_pkg::STAMP_BITS-1:0] rd_stamp_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.entry_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    // Valid bits clear at reset; entries only ever become valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.entry_en)
        begin
            key_mem[wr_addr]    <= wr_key;
            handle_mem[wr_addr] <= wr_handle;
        end
        if (wr.stamp_en)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        rd_key_reg    <= key_mem[rd_addr];
        rd_handle_reg <= handle_mem[rd_addr];
        rd_stamp_reg  <= stamp_mem[rd_addr];
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_key    = rd_key_reg;
    assign rd_handle = rd_handle_reg;
    assign rd_stamp  = rd_stamp_reg;

endmodule

FILE: rtl/assoc_cache_mru_evict.sv
// Fully associative key-to-handle cache with most-recently-used eviction.
// Input channel (s_axis_*): one transfer carries one operation. tuser bit 0
// selects get (0) or put (1); tdata carries the key and, for a put, the handle.
// Output channel (m_axis_*): exactly one result transfer per operation, in
// order. A get reports hit, the stored handle and the entry index. A put
// reports the entry written and, when every entry was valid, the evicted
// entry's handle so that the user can release it.
// Timing: each operation walks all ENTRIES entries through the single read
// port of the entry store, one entry per cycle, with one shared key and stamp
// comparator. The result is loaded into the output register after the scan, a
// drain state and the write-back, and no new operation is taken until the last
// one has been written back. The scan length is set by the store read port.
// s_axis_tready is high only while the sequencer is idle.
// Stalls: the result sits in an output register. If the receiver holds
// m_axis_tready low, the sequencer waits after its write-back until the
// register is free; the cache state is already updated at that point.
// Reset: all entries become invalid and the use counter returns to zero.
module assoc_cache_mru_evict #(
    parameter int ENTRIES     = acme_pkg::ENTRIES_DEF,
    parameter int KEY_BITS    = acme_pkg::KEY_BITS_DEF,
    parameter int HANDLE_BITS = acme_pkg::HANDLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] lookup_key, [31:16] handle_in
    input  logic [acme_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // [0] opcode
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] handle_out, [19:16] slot_used, [35:20] evicted_handle, [39:36] zero
    output logic [acme_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    // [0] hit, [1] evicted
    output logic [acme_pkg::OUT_USER_BITS-1:0] m_axis_tuser
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam int FB = acme_pkg::FIELD_BITS;
    localparam int SB = acme_pkg::STAMP_BITS;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   found_reg, found_next;
    logic [SB-1:0]          use_count_reg, use_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   wait_out_reg, wait_out_next;

    // Operation payload and scan results.
    logic                   op_reg, op_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [HANDLE_BITS-1:0] handle_reg, handle_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [HANDLE_BITS-1:0] hout_reg, hout_next;
    logic [SB-1:0]          best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;

    // Output register.
    logic                   out_hit_reg, out_evicted_reg;
    logic [FB-1:0]          out_hout_reg, out_evh_reg;
    logic [acme_pkg::SLOT_BITS-1:0] out_slot_reg;

    logic                   rd_valid;
    logic [KEY_BITS-1:0]    rd_key;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [SB-1:0]          rd_stamp;
    acme_pkg::acme_wr_t     wr;
    logic [IDX_W-1:0]       slot_sel;
    logic [SB-1:0]          stamp_new;
    logic                   do_stamp;
    logic                   out_free;
    logic                   load_out;
    logic                   accept;
    logic                   res_hit, res_evict;

    acme_store #(
        .ENTRIES     (ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_idx_reg),
        .rd_valid  (rd_valid),
        .rd_key    (rd_key),
        .rd_handle (rd_handle),
        .rd_stamp  (rd_stamp),
        .wr        (wr),
        .wr_addr   (slot_sel),
        .wr_key    (key_reg),
        .wr_handle (handle_reg),
        .wr_stamp  (stamp_new)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !wait_out_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // A put that found no free entry replaces the victim with the highest stamp.
    assign slot_sel  = (op_reg == acme_pkg::OP_PUT && !found_reg) ? best_idx_reg : slot_reg;
    assign do_stamp  = (op_reg == acme_pkg::OP_PUT) || found_reg;
    assign stamp_new = use_count_reg + SB'(1);
    assign res_hit   = (op_reg == acme_pkg::OP_GET) && found_reg;
    assign res_evict = (op_reg == acme_pkg::OP_PUT) && !found_reg;

    always_comb
    begin
        wr.stamp_en = (state_reg == S_WRITE) && do_stamp;
        wr.entry_en = (state_reg == S_WRITE) && (op_reg == acme_pkg::OP_PUT);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        use_count_next = use_count_reg;
        wait_out_next  = wait_out_reg;
        cmp_vld_next   = (state_reg == S_SCAN);
        cmp_idx_next   = rd_idx_reg;
        load_out       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (wait_out_reg)
                begin
                    if (out_free)
                    begin
                        load_out      = 1'b1;
                        wait_out_next = 1'b0;
                    end
                end
                else if (s_axis_tvalid)
                begin
                    op_next     = s_axis_tuser;
                    key_next    = KEY_BITS'(s_axis_tdata[FB-1:0]);
                    handle_next = HANDLE_BITS'(s_axis_tdata[2*FB-1:FB]);
                    rd_idx_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (do_stamp)
                begin
                    use_count_next = stamp_new;
                end
                // Park in idle with the result held until the output is free.
                if (out_free)
                begin
                    load_out = 1'b1;
                end
                else
                begin
                    wait_out_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shared compare unit: one entry per cycle, in the cycle after its read address.
    always_comb
    begin
        found_next       = found_reg;
        slot_next        = slot_reg;
        hout_next        = hout_reg;
        best_stamp_next  = best_stamp_reg;
        best_idx_next    = best_idx_reg;
        best_handle_next = best_handle_reg;

        if (accept)
        begin
            found_next = 1'b0;
        end
        else if (cmp_vld_reg)
        begin
            if (!found_reg)
            begin
                if (op_reg == acme_pkg::OP_GET)
                begin
                    if (rd_valid && (rd_key == key_reg))
                    begin
                        found_next = 1'b1;
                        slot_next  = cmp_idx_reg;
                        hout_next  = rd_handle;
                    end
                end
                else if (!rd_valid)
                begin
                    found_next = 1'b1;
                    slot_next  = cmp_idx_reg;
                end
            end
            // Strictly greater wins, so ties keep the lower index.
            if ((cmp_idx_reg == '0) || (rd_stamp > best_stamp_reg))
            begin
                best_stamp_next  = rd_stamp;
                best_idx_next    = cmp_idx_reg;
                best_handle_next = rd_handle;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            found_reg     <= 1'b0;
            use_count_reg <= '0;
            out_valid_reg <= 1'b0;
            wait_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_reg     <= found_next;
            use_count_reg <= use_count_next;
            out_valid_reg <= out_valid_next;
            wait_out_reg  <= wait_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        handle_reg      <= handle_next;
        slot_reg        <= slot_next;
        hout_reg        <= hout_next;
        best_stamp_reg  <= best_stamp_next;
        best_idx_reg    <= best_idx_next;
        best_handle_reg <= best_handle_next;
        if (load_out)
        begin
            out_hit_reg     <= res_hit;
            out_evicted_reg <= res_evict;
            out_hout_reg    <= res_hit ? FB'(hout_reg) : '0;
            out_slot_reg    <= (op_reg == acme_pkg::OP_PUT || found_reg)
                               ? acme_pkg::SLOT_BITS'(slot_sel) : '0;
            out_evh_reg     <= res_evict ? FB'(best_handle_reg) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{acme_pkg::OUT_PAD_BITS{1'b0}}, out_evh_reg, out_slot_reg,
                            out_hout_reg};
    assign m_axis_tuser  = {out_evicted_reg, out_hit_reg};

    // An accepted operation closes the input until its result is produced.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input accepted while an operation was in progress");

    // The use counter only advances during write-back.
    a_count_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_WRITE) |=> $stable(use_count_reg))
        else $error("use counter changed outside write-back");

    // A result is never both a hit and an eviction.
    a_hit_evict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result flags hit and evicted together");

    // The store is written only after a full scan.
    a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.stamp_en || wr.entry_en) |-> $past(state_reg == S_DRAIN))
        else $error("entry store written without a completed scan");

endmodule
